// ===== hw/rtl/bst_pkg.sv =====
// bst_pkg: shared types, sizes and codes of the bounded set table
// used by bst_ram users and bounded_set_table_top; depends on nothing

package bst_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_WIDTH = 32;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MEMBER = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  // sign extend the 32-bit request key, keep the low KEY_WIDTH bits
  function automatic key_t norm_key(input logic [31:0] raw);
    logic [63:0] ext;
    ext = {{32{raw[31]}}, raw};
    return ext[KEY_WIDTH-1:0];
  endfunction

endpackage

// ===== hw/rtl/bst_ram.sv =====
// bst_ram: generic simple dual-port ram, one write and one registered read port
// stand-alone, no package needed

module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bounded_set_table_top.sv =====
// bounded_set_table_top: set of distinct keys kept dense in one ram
// depends on bst_pkg and bst_ram
//
//   channel | direction | ports                                  | handshake
//   --------+-----------+----------------------------------------+-------------------
//   in_     | input     | in_opcode, in_key                      | in_valid / in_stall
//   out_    | output    | out_status, out_was_present, out_set_size | out_valid / out_stall
//
// scan: a request compares n stored keys, n being the set size, fewer on an early
//   hit, and none on an empty set; the scan is paced by the single ram read port,
//   which delivers one stored key per cycle to the compare
// reset: rst_n clears the key count, fsm and output valid; the ram needs no clearing
// stalls: the result sits in an output register; a new request is taken while it waits,
//   only the final write-back step holds until that register is free

module bounded_set_table_top (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic signed [31:0] in_key,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_was_present,
  output logic [5:0]  out_set_size
);

  // control state
  bst_pkg::state_t state_r, state_nxt;
  bst_pkg::cnt_t   count_r, count_nxt;
  logic            issue_r, issue_nxt;     // more ram reads to issue
  logic            cmp_vld_r, cmp_vld_nxt; // ram data valid for compare
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;

  // request and scan payload
  logic [1:0]        op_r, op_nxt;
  bst_pkg::key_t     key_r, key_nxt;
  bst_pkg::addr_t    idx_r, idx_nxt;       // next address to read, counts down
  bst_pkg::addr_t    cmp_idx_r, cmp_idx_nxt;
  bst_pkg::addr_t    slot_r, slot_nxt;     // where the key was found
  bst_pkg::key_t     last_key_r, last_key_nxt; // top entry, fills a removal gap

  // result register
  logic [1:0] out_status_r, out_status_nxt;
  logic       out_pres_r, out_pres_nxt;
  logic [5:0] out_size_r, out_size_nxt;

  // ram port
  logic           ram_we, ram_re;
  bst_pkg::addr_t ram_waddr, ram_raddr;
  bst_pkg::key_t  ram_wdata, ram_rdata;

  logic           in_fire, fin_fire, is_full;
  bst_pkg::addr_t top_idx;

  assign in_stall  = (state_r != bst_pkg::S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  // finish once the result register is free or being drained
  assign fin_fire  = (state_r == bst_pkg::S_FIN) && (!out_valid_r || !out_stall);
  assign top_idx   = bst_pkg::ADDR_W'(count_r - bst_pkg::CNT_W'(1));
  assign is_full   = (count_r == bst_pkg::CNT_W'(bst_pkg::CAPACITY));

  assign ram_re    = (state_r == bst_pkg::S_SCAN) && issue_r;
  assign ram_raddr = idx_r;

  bst_ram #(
    .WIDTH (bst_pkg::KEY_WIDTH),
    .DEPTH (bst_pkg::CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    cmp_vld_nxt    = 1'b0;
    found_nxt      = found_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = idx_r;
    slot_nxt       = slot_r;
    last_key_nxt   = last_key_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pres_nxt   = out_pres_r;
    out_size_nxt   = out_size_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[bst_pkg::ADDR_W-1:0];
    ram_wdata      = key_r;

    unique case (state_r)
      bst_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_opcode;
          key_nxt   = bst_pkg::norm_key(in_key);
          found_nxt = 1'b0;
          // scan from the top entry down, so it is read first
          idx_nxt   = top_idx;
          issue_nxt = (count_r != '0);
          state_nxt = (count_r != '0) ? bst_pkg::S_SCAN : bst_pkg::S_FIN;
        end
      end

      bst_pkg::S_SCAN: begin
        // read stage
        if (issue_r) begin
          if (idx_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - bst_pkg::ADDR_W'(1);
          end
        end
        cmp_vld_nxt = issue_r;

        // compare stage, in the cycle after the read
        if (cmp_vld_r) begin
          if (cmp_idx_r == top_idx) begin
            last_key_nxt = ram_rdata;
          end
          if (ram_rdata == key_r) begin
            found_nxt   = 1'b1;
            slot_nxt    = cmp_idx_r;
            issue_nxt   = 1'b0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = bst_pkg::S_FIN;
          end else if (cmp_idx_r == '0) begin
            cmp_vld_nxt = 1'b0;
            state_nxt   = bst_pkg::S_FIN;
          end
        end
      end

      bst_pkg::S_FIN: begin
        if (fin_fire) begin
          out_valid_nxt  = 1'b1;
          out_pres_nxt   = found_r;
          out_status_nxt = bst_pkg::ST_DONE;
          unique case (op_r)
            bst_pkg::OP_ADD: begin
              if (found_r) begin
                out_status_nxt = bst_pkg::ST_PRESENT;
              end else if (is_full) begin
                out_status_nxt = bst_pkg::ST_FULL;
              end else begin
                // append at the top
                ram_we    = 1'b1;
                count_nxt = count_r + bst_pkg::CNT_W'(1);
              end
            end
            bst_pkg::OP_REMOVE: begin
              if (!found_r) begin
                out_status_nxt = bst_pkg::ST_NOT_FOUND;
              end else begin
                // top entry moves into the gap
                ram_we    = 1'b1;
                ram_waddr = slot_r;
                ram_wdata = last_key_r;
                count_nxt = count_r - bst_pkg::CNT_W'(1);
              end
            end
            default: begin
              // membership test, unused opcode alike
            end
          endcase
          out_size_nxt = 6'(count_nxt);
          state_nxt    = bst_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bst_pkg::S_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    slot_r       <= slot_nxt;
    last_key_r   <= last_key_nxt;
    out_status_r <= out_status_nxt;
    out_pres_r   <= out_pres_nxt;
    out_size_r   <= out_size_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_was_present = out_pres_r;
  assign out_set_size    = out_size_r;

  // the table never holds more keys than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bst_pkg::CNT_W'(bst_pkg::CAPACITY))
    else $error("key count beyond capacity");

  // a hit always points at a live entry
  a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bst_pkg::S_FIN) && found_r |->
      (bst_pkg::CNT_W'(slot_r) < count_r))
    else $error("found slot outside the live entries");

  // a successful remove shrinks the set by exactly one
  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire && found_r && (op_r == bst_pkg::OP_REMOVE) |=>
      count_r == $past(count_r) - bst_pkg::CNT_W'(1))
    else $error("remove did not shrink the set");

  // ram writes happen only while finishing a request
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> fin_fire && (op_r == bst_pkg::OP_ADD || op_r == bst_pkg::OP_REMOVE))
    else $error("ram write outside write-back");

endmodule

// ===== verif/bounded_set_table_top_test.sv =====
`timescale 1ns / 1ps
// bounded_set_table_top_test: self-checking bench for the bounded set table
// depends on bst_pkg and bounded_set_table_top; runs add/remove/member requests
// through the valid/stall channels and checks each result against its own set model

module bounded_set_table_top_test;

  // opcode 3 is not named in the package; the block treats it as a lookup
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE = 40;

  typedef struct packed {
    bst_pkg::status_t status;
    logic             was_present;
    logic [5:0]       set_size;
  } set_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic signed [31:0] in_key;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_was_present;
  logic [5:0]  out_set_size;

  bounded_set_table_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_was_present (out_was_present),
    .out_set_size    (out_set_size)
  );

  // model of the table: dense key list plus count
  bst_pkg::key_t model_keys [bst_pkg::CAPACITY];
  int            model_count;
  set_result_t   expected_results [$];

  // keys reused often so that adds collide and removes hit
  logic [31:0] key_pool [POOL_SIZE];

  // idle rates in percent, set per phase
  int send_idle_pct;
  int recv_idle_pct;

  // long receiver hold-off: a bump of hold_trigger starts one
  int hold_trigger;
  int hold_seen = 0;
  int hold_count = 0;

  int error_count;
  int requests_sent;
  int results_checked;
  int largest_size;
  int status_seen [4];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // apply one request to the model and return the result it must produce
  function automatic set_result_t apply_set_op(input logic [1:0] op, input logic [31:0] raw_key);
    logic [63:0]   wide;
    bst_pkg::key_t k;
    int            slot;
    set_result_t   r;
    // keys are sign extended, then cut to the table's key width
    wide = {{32{raw_key[31]}}, raw_key};
    k = wide[bst_pkg::KEY_WIDTH-1:0];
    slot = model_count;
    for (int i = 0; i < model_count; i++) begin
      if (slot == model_count && model_keys[i] == k) slot = i;
    end
    r.was_present = (slot < model_count);
    r.status = bst_pkg::ST_DONE;
    case (op)
      bst_pkg::OP_ADD: begin
        if (r.was_present) begin
          r.status = bst_pkg::ST_PRESENT;
        end else if (model_count >= bst_pkg::CAPACITY) begin
          r.status = bst_pkg::ST_FULL;
        end else begin
          model_keys[model_count] = k;
          model_count++;
        end
      end
      bst_pkg::OP_REMOVE: begin
        if (!r.was_present) begin
          r.status = bst_pkg::ST_NOT_FOUND;
        end else begin
          // last entry fills the gap so the list stays dense
          model_count--;
          model_keys[slot] = model_keys[model_count];
        end
      end
      default: ;
    endcase
    r.set_size = 6'(model_count);
    return r;
  endfunction

  // mostly keys already held or from the pool, the rest fully random
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40 && model_count > 0) return model_keys[$urandom_range(model_count - 1)];
    if (r < 75) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // offer one request, optionally after a random gap, and predict it once taken
  task automatic send_request(input logic [1:0] op, input logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    // values read right after the edge are the ones the block sampled
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_set_op(op, key));
    requests_sent++;
  endtask

  // sender goes quiet until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk);
  endtask

  // extremes of the key, every opcode and each corner of add/remove/lookup
  task automatic test_directed_cases();
    send_request(bst_pkg::OP_MEMBER, 32'h0000_0000);     // lookup on empty set
    send_request(bst_pkg::OP_REMOVE, 32'h8000_0000);     // remove from empty set
    send_request(bst_pkg::OP_ADD,    32'h8000_0000);
    send_request(bst_pkg::OP_ADD,    32'h7fff_ffff);
    send_request(bst_pkg::OP_ADD,    32'h0000_0000);
    send_request(bst_pkg::OP_ADD,    32'hffff_ffff);
    send_request(bst_pkg::OP_ADD,    32'h7fff_ffff);     // already present
    send_request(bst_pkg::OP_MEMBER, 32'h0000_0000);
    send_request(bst_pkg::OP_MEMBER, 32'h1234_5678);     // absent
    send_request(OP_UNUSED,          32'hffff_ffff);     // unused opcode on a held key
    send_request(OP_UNUSED,          32'h5555_5555);     // unused opcode on an absent key
    send_request(bst_pkg::OP_REMOVE, 32'h7fff_ffff);     // middle entry, last one moves in
    send_request(bst_pkg::OP_MEMBER, 32'hffff_ffff);     // moved entry still found
    send_request(bst_pkg::OP_REMOVE, 32'h7fff_ffff);     // now absent
    send_request(bst_pkg::OP_ADD,    32'h5555_5555);
    send_request(bst_pkg::OP_ADD,    32'haaaa_aaaa);
    send_request(bst_pkg::OP_REMOVE, 32'h8000_0000);     // first entry
    send_request(bst_pkg::OP_REMOVE, 32'haaaa_aaaa);     // first entry, moved there by the previous remove
    send_request(bst_pkg::OP_MEMBER, 32'h5555_5555);
    send_request(bst_pkg::OP_MEMBER, 32'h8000_0000);
    drain_results();
  endtask

  // fill the table, hit it while full, then empty it completely
  task automatic test_fill_to_capacity();
    while (model_count < bst_pkg::CAPACITY) send_request(bst_pkg::OP_ADD, $urandom());
    send_request(bst_pkg::OP_ADD, $urandom());                          // no room left
    send_request(bst_pkg::OP_ADD,
                 model_keys[$urandom_range(bst_pkg::CAPACITY - 1)]);   // present while full
    send_request(bst_pkg::OP_MEMBER, model_keys[bst_pkg::CAPACITY - 1]);
    send_request(bst_pkg::OP_REMOVE, model_keys[bst_pkg::CAPACITY - 1]);
    send_request(bst_pkg::OP_ADD, 32'h8000_0000);
    send_request(bst_pkg::OP_ADD, 32'h7fff_ffff);                       // full again or present
    while (model_count > 0) begin
      send_request(bst_pkg::OP_REMOVE, model_keys[$urandom_range(model_count - 1)]);
    end
    send_request(bst_pkg::OP_REMOVE, 32'h0000_0000);                    // empty again
    drain_results();
  endtask

  // receiver blocks for a long stretch while requests keep coming
  task automatic test_output_holdoff();
    int r;
    hold_trigger <= hold_trigger + 1;
    repeat (24) begin
      r = $urandom_range(2);
      send_request(r == 0 ? bst_pkg::OP_ADD :
                   (r == 1 ? bst_pkg::OP_REMOVE : bst_pkg::OP_MEMBER), pick_key());
    end
    drain_results();
  endtask

  // weighted mix: first half leans to adds, second half to removes
  task automatic test_random_mix(input int n_items);
    int          r;
    int          add_pct;
    int          rem_pct;
    logic [1:0]  op;
    for (int n = 0; n < n_items; n++) begin
      add_pct = (n < n_items / 2) ? 55 : 25;
      rem_pct = (n < n_items / 2) ? 25 : 55;
      r = $urandom_range(99);
      if (r < add_pct) op = bst_pkg::OP_ADD;
      else if (r < add_pct + rem_pct) op = bst_pkg::OP_REMOVE;
      else if (r < 95) op = bst_pkg::OP_MEMBER;
      else op = OP_UNUSED;
      send_request(op, pick_key());
    end
    drain_results();
  endtask

  // receiver side: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen  <= hold_trigger;
      hold_count <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // every result taken is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      status_seen[out_status]++;
      if (out_set_size > largest_size) largest_size = out_set_size;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d was_present %0b set_size %0d",
               out_status, out_was_present, out_set_size);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_was_present !== want.was_present) begin
          $error("was_present: expected %0b, got %0b", want.was_present, out_was_present);
          error_count++;
        end
        if (out_set_size !== want.set_size) begin
          $error("set_size: expected %0d, got %0d", want.set_size, out_set_size);
          error_count++;
        end
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = bst_pkg::OP_ADD;
    in_key        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger  = 0;
    model_count   = 0;
    error_count   = 0;
    requests_sent = 0;
    results_checked = 0;
    largest_size  = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (model_keys[i]) model_keys[i] = '0;

    // pool keeps the sign and width extremes plus random fill
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender idles lightly, receiver stalls often
    send_idle_pct = 20;
    recv_idle_pct = 56;
    test_directed_cases();
    test_fill_to_capacity();
    test_output_holdoff();
    test_random_mix(155);

    // phase two: roles swapped
    send_idle_pct = 56;
    recv_idle_pct = 20;
    test_random_mix(155);

    // phase three: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_to_capacity();
    test_random_mix(155);

    // let anything stray show up before judging
    drain_results();
    repeat (bst_pkg::CAPACITY + 8) @(posedge clk);

    $display("ran %0d requests, checked %0d results, largest set size %0d",
             requests_sent, results_checked, largest_size);
    $display("status mix done/present/not found/full: %0d/%0d/%0d/%0d",
             status_seen[bst_pkg::ST_DONE], status_seen[bst_pkg::ST_PRESENT],
             status_seen[bst_pkg::ST_NOT_FOUND], status_seen[bst_pkg::ST_FULL]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bst_pkg.sv
hw/rtl/bst_ram.sv
hw/rtl/bounded_set_table_top.sv
verif/bounded_set_table_top_test.sv
